### src/crk4_pkg.sv
// Shared types, constants and the saturation helper for the companion-form RK4 plant step.
// No dependencies; used by companion_form_rk4_plant_step, crk4_plant_checker and the bench.
`default_nettype none

package crk4_pkg;

	// Register file layout
	localparam int NUM_COEF  = 5;
	localparam int COEF_W    = 24;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_COEF_0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF_4 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_GAIN   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_STEP   = 3'd6;

	localparam logic [COEF_W-1:0] STEP_RESET = 24'd16777;

	// Datapath widths
	localparam int DATA_W = 32;   // Q16.16 state, drive and derivatives
	localparam int KSUM_W = 35;   // k1 + 2k2 + 2k3 + k4
	localparam int MA_W   = 35;   // multiplier operand A (signed)
	localparam int MB_W   = 25;   // multiplier operand B (signed, holds unsigned h)
	localparam int P_W    = 60;   // product
	localparam int ACC_W  = 58;   // last-row accumulator, Q26.32
	localparam int TAG_IDX_W = 3;

	// Floor division by six, one byte per cycle
	localparam int DIV_W = 40;
	localparam logic [2:0] DIV_LAST = 3'd4;                 // five byte steps
	localparam logic [DIV_W-1:0] DIV_OFS = 40'd25769803776; // 6 * 2^32, keeps dividend positive
	localparam logic signed [63:0] DIV_BIAS = 64'sd4294967296; // 2^32 = DIV_OFS / 6
	localparam logic [11:0] RECIP_6  = 12'd2731;            // ceil(2^14 / 6)
	localparam logic [3:0]  DIVISOR  = 4'd6;

	// Sequencer states
	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_DERIV     = 9'b000000010,
		S_GAP       = 9'b000000100,
		S_STAGE     = 9'b000001000,
		S_FINAL_MUL = 9'b000010000,
		S_FINAL_CAP = 9'b000100000,
		S_DIV       = 9'b001000000,
		S_FINAL_WR  = 9'b010000000,
		S_DONE      = 9'b100000000
	} state_t;

	// Travels with a product so the consume side knows what to do with it
	typedef struct packed {
		logic                 deriv;
		logic                 stage;
		logic                 first;
		logic                 last;
		logic                 half;
		logic [TAG_IDX_W-1:0] idx;
	} tag_t;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              clip;
	} sat_t;

	// Clip a wide signed value to the signed 32-bit range
	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.val  = 32'h7fff_ffff;
			r.clip = 1'b1;
		end else if (v < -64'sd2147483648) begin
			r.val  = 32'h8000_0000;
			r.clip = 1'b1;
		end else begin
			r.val  = v[DATA_W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### src/companion_form_rk4_plant_step.sv
// Companion-form linear plant, one classical RK4 step per drive sample.
// Depends on crk4_pkg (types, constants, sat32).
`default_nettype none

// Each accepted drive sample advances the ORDER-element plant state by one
// fourth-order Runge-Kutta step of size h and returns y = x0 plus a flag
// that is set when any derivative, stage state or new state clipped to 32
// bits. All arithmetic runs through one 35x25 multiplier under a small
// sequencer: four derivative passes, three stage passes, ORDER final
// updates, each dominated by a byte-serial divide by six, and a load of
// the output register. in_stall is high while an item is in work; the
// finished result sits in an output register, and a new item is taken in
// the cycle after that result has been loaded there, so the block takes
// no new drive sample before it is through with the last one.
// Configuration writes should be made only while the block is idle.
module companion_form_rk4_plant_step #(
	parameter int ORDER = 3
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 wr_en,
	input  wire logic [crk4_pkg::REG_IDX_W-1:0]       wr_index,
	input  wire logic [crk4_pkg::COEF_W-1:0]          wr_data,
	// drive samples
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [crk4_pkg::DATA_W-1:0]   drive,
	// results
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [crk4_pkg::DATA_W-1:0]        plant_output,
	output logic                                      saturated
);

	localparam int IDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;
	localparam int CNT_W = $clog2(ORDER + 1);
	localparam logic [CNT_W-1:0] CNT_LAST_TERM = CNT_W'(ORDER);
	localparam logic [CNT_W-1:0] CNT_LAST_ELEM = CNT_W'(ORDER - 1);

	// Registers and state
	logic signed [crk4_pkg::COEF_W-1:0] coef_q [0:crk4_pkg::NUM_COEF-1];
	logic signed [crk4_pkg::COEF_W-1:0] gain_q;
	logic        [crk4_pkg::COEF_W-1:0] step_q;

	logic signed [crk4_pkg::DATA_W-1:0] x_q    [0:ORDER-1];
	logic signed [crk4_pkg::DATA_W-1:0] s_q    [0:ORDER-1];
	logic signed [crk4_pkg::KSUM_W-1:0] ksum_q [0:ORDER-1];
	logic signed [crk4_pkg::DATA_W-1:0] klast_q;
	logic signed [crk4_pkg::DATA_W-1:0] u_q;
	logic signed [crk4_pkg::ACC_W-1:0]  acc_q;
	logic signed [crk4_pkg::P_W-1:0]    p_s1;
	crk4_pkg::tag_t                     tag_s1;
	crk4_pkg::state_t                   state_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic [1:0]                         rk_q;
	logic [2:0]                         dcnt_q;
	logic [crk4_pkg::DIV_W-1:0]         div_q;
	logic [2:0]                         rem_q;
	logic                               sat_q;
	logic                               out_valid_q;
	logic signed [crk4_pkg::DATA_W-1:0] plant_output_q;
	logic                               saturated_q;

	logic in_xfer;
	logic out_load;
	logic last_elem;

	assign in_stall  = (state_q != crk4_pkg::S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_load  = (state_q == crk4_pkg::S_DONE) && (!out_valid_q || !out_stall);
	assign last_elem = (cnt_q == CNT_LAST_ELEM);

	// Operand fetch: stage state, derivative element, coefficient, k sum
	logic [CNT_W-1:0]                   s_rd_addr;
	logic signed [crk4_pkg::DATA_W-1:0] s_rd;
	logic signed [crk4_pkg::DATA_W-1:0] kop;
	logic [crk4_pkg::REG_IDX_W-1:0]     coef_idx;
	logic signed [crk4_pkg::COEF_W-1:0] coef_rd;
	logic signed [crk4_pkg::KSUM_W-1:0] ksum_rd;
	logic signed [crk4_pkg::KSUM_W-1:0] fin_sum;

	always_comb begin
		if (state_q == crk4_pkg::S_DERIV) begin
			s_rd_addr = cnt_q - CNT_W'(1);
		end else begin
			s_rd_addr = cnt_q + CNT_W'(1);
		end
	end

	assign s_rd     = (s_rd_addr < CNT_LAST_TERM) ? s_q[s_rd_addr[IDX_W-1:0]] : '0;
	assign kop      = last_elem ? klast_q : s_rd;
	assign coef_idx = crk4_pkg::REG_IDX_W'(cnt_q) - crk4_pkg::REG_IDX_W'(1);
	assign coef_rd  = coef_q[coef_idx];
	assign ksum_rd  = ksum_q[cnt_q[IDX_W-1:0]];
	assign fin_sum  = ksum_rd + {{(crk4_pkg::KSUM_W - crk4_pkg::DATA_W){kop[31]}}, kop};

	// Shared multiplier: operand select and issue tag
	logic signed [crk4_pkg::MA_W-1:0] ma;
	logic signed [crk4_pkg::MB_W-1:0] mb;
	logic signed [crk4_pkg::P_W-1:0]  mul_w;
	crk4_pkg::tag_t                   tag_n;

	always_comb begin
		ma    = '0;
		mb    = '0;
		tag_n = '0;
		unique case (state_q)
			crk4_pkg::S_DERIV: begin
				if (cnt_q == '0) begin
					ma = crk4_pkg::MA_W'(u_q);
					mb = crk4_pkg::MB_W'(gain_q);
				end else begin
					ma = crk4_pkg::MA_W'(s_rd);
					mb = crk4_pkg::MB_W'(coef_rd);
				end
				tag_n.deriv = 1'b1;
				tag_n.first = (cnt_q == '0);
				tag_n.last  = (cnt_q == CNT_LAST_TERM);
			end
			crk4_pkg::S_STAGE: begin
				ma          = crk4_pkg::MA_W'(kop);
				mb          = $signed({1'b0, step_q});
				tag_n.stage = 1'b1;
				tag_n.half  = (rk_q != 2'd2);
				tag_n.idx   = crk4_pkg::TAG_IDX_W'(cnt_q);
			end
			crk4_pkg::S_FINAL_MUL: begin
				ma = fin_sum;
				mb = $signed({1'b0, step_q});
			end
			crk4_pkg::S_IDLE, crk4_pkg::S_GAP, crk4_pkg::S_FINAL_CAP, crk4_pkg::S_DIV,
			crk4_pkg::S_FINAL_WR, crk4_pkg::S_DONE: begin
				ma = '0;
			end
			default: begin
				ma = '0;
			end
		endcase
	end

	assign mul_w = ma * mb;

	// Consume side: last derivative row, stage states, final update
	logic signed [crk4_pkg::ACC_W-1:0]  acc_term;
	logic signed [crk4_pkg::ACC_W-1:0]  acc_next;
	crk4_pkg::sat_t                     kl_sat;
	logic signed [crk4_pkg::P_W-1:0]    stage_inc;
	logic [IDX_W-1:0]                   x_rd_addr;
	logic signed [crk4_pkg::DATA_W-1:0] x_rd;
	crk4_pkg::sat_t                     stage_sat;
	logic signed [crk4_pkg::P_W-1:0]    fin_shift;
	logic signed [crk4_pkg::KSUM_W-1:0] fin_q35;
	logic [crk4_pkg::DIV_W-1:0]         div_load;
	logic signed [63:0]                 fin_inc;
	crk4_pkg::sat_t                     fin_sat;

	assign acc_term = $signed(p_s1[crk4_pkg::ACC_W-1:0]);
	assign acc_next = tag_s1.first ? acc_term : (acc_q - acc_term);
	assign kl_sat   = crk4_pkg::sat32(64'(acc_next >>> 16));

	assign stage_inc = tag_s1.half ? (p_s1 >>> 25) : (p_s1 >>> 24);
	assign x_rd_addr = (state_q == crk4_pkg::S_FINAL_WR) ? cnt_q[IDX_W-1:0]
	                                                    : tag_s1.idx[IDX_W-1:0];
	assign x_rd      = x_q[x_rd_addr];
	assign stage_sat = crk4_pkg::sat32(64'(x_rd) + 64'(stage_inc));

	// floor(h*sum / 2^24), offset so the divide by six works on a positive value
	assign fin_shift = p_s1 >>> 24;
	assign fin_q35   = $signed(fin_shift[crk4_pkg::KSUM_W-1:0]);
	assign div_load  = {{(crk4_pkg::DIV_W - crk4_pkg::KSUM_W){fin_q35[crk4_pkg::KSUM_W-1]}},
	                    fin_q35} + crk4_pkg::DIV_OFS;

	// One quotient byte per cycle by reciprocal multiply
	logic [10:0] dv;
	logic [22:0] dprod;
	logic [7:0]  digit;
	logic [10:0] drem;

	assign dv    = {rem_q, div_q[crk4_pkg::DIV_W-1 -: 8]};
	assign dprod = 23'(dv) * 23'(crk4_pkg::RECIP_6);
	assign digit = dprod[21:14];
	assign drem  = dv - (11'(digit) * 11'(crk4_pkg::DIVISOR));

	assign fin_inc = $signed({24'b0, div_q}) - crk4_pkg::DIV_BIAS;
	assign fin_sat = crk4_pkg::sat32(64'(x_rd) + fin_inc);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crk4_pkg::S_IDLE;
			cnt_q   <= '0;
			rk_q    <= '0;
			dcnt_q  <= '0;
			tag_s1  <= '0;
		end else begin
			tag_s1 <= tag_n;
			unique case (state_q)
				crk4_pkg::S_IDLE: begin
					if (in_valid) begin
						state_q <= crk4_pkg::S_DERIV;
						cnt_q   <= '0;
						rk_q    <= '0;
					end
				end
				crk4_pkg::S_DERIV: begin
					if (cnt_q == CNT_LAST_TERM) begin
						state_q <= crk4_pkg::S_GAP;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				crk4_pkg::S_GAP: begin
					if (rk_q == 2'd3) begin
						state_q <= crk4_pkg::S_FINAL_MUL;
					end else begin
						state_q <= crk4_pkg::S_STAGE;
					end
				end
				crk4_pkg::S_STAGE: begin
					if (last_elem) begin
						state_q <= crk4_pkg::S_DERIV;
						cnt_q   <= '0;
						rk_q    <= rk_q + 2'd1;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				crk4_pkg::S_FINAL_MUL: begin
					state_q <= crk4_pkg::S_FINAL_CAP;
				end
				crk4_pkg::S_FINAL_CAP: begin
					state_q <= crk4_pkg::S_DIV;
					dcnt_q  <= '0;
				end
				crk4_pkg::S_DIV: begin
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == crk4_pkg::DIV_LAST) begin
						state_q <= crk4_pkg::S_FINAL_WR;
					end
				end
				crk4_pkg::S_FINAL_WR: begin
					if (last_elem) begin
						state_q <= crk4_pkg::S_DONE;
						cnt_q   <= '0;
					end else begin
						state_q <= crk4_pkg::S_FINAL_MUL;
						cnt_q   <= cnt_q + CNT_W'(1);
					end
				end
				crk4_pkg::S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= crk4_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= crk4_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Configuration registers, plant state and clip flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < crk4_pkg::NUM_COEF; j++) begin
				coef_q[j] <= '0;
			end
			gain_q <= '0;
			step_q <= crk4_pkg::STEP_RESET;
			for (int j = 0; j < ORDER; j++) begin
				x_q[j] <= '0;
			end
			sat_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index) inside
					[crk4_pkg::REG_COEF_0:crk4_pkg::REG_COEF_4]: coef_q[wr_index] <= wr_data;
					crk4_pkg::REG_GAIN: gain_q <= wr_data;
					crk4_pkg::REG_STEP: step_q <= wr_data;
					default: ;
				endcase
			end
			if (state_q == crk4_pkg::S_FINAL_WR) begin
				x_q[cnt_q[IDX_W-1:0]] <= fin_sat.val;
			end
			if (in_xfer) begin
				sat_q <= 1'b0;
			end else if ((tag_s1.deriv && tag_s1.last && kl_sat.clip)
			          || (tag_s1.stage && stage_sat.clip)
			          || ((state_q == crk4_pkg::S_FINAL_WR) && fin_sat.clip)) begin
				sat_q <= 1'b1;
			end
		end
	end

	// Working registers of the step
	always_ff @(posedge clk) begin
		p_s1 <= mul_w;
		if (in_xfer) begin
			u_q <= drive;
			for (int j = 0; j < ORDER; j++) begin
				s_q[j] <= x_q[j];
			end
		end
		// last derivative row
		if (tag_s1.deriv) begin
			acc_q <= acc_next;
			if (tag_s1.last) begin
				klast_q <= kl_sat.val;
			end
		end
		// stage state element
		if (tag_s1.stage) begin
			s_q[tag_s1.idx[IDX_W-1:0]] <= stage_sat.val;
		end
		// weighted derivative sum k1 + 2k2 + 2k3
		if (state_q == crk4_pkg::S_STAGE) begin
			if (rk_q == 2'd0) begin
				ksum_q[cnt_q[IDX_W-1:0]] <= crk4_pkg::KSUM_W'(kop);
			end else begin
				ksum_q[cnt_q[IDX_W-1:0]] <= ksum_rd
					+ {{(crk4_pkg::KSUM_W - crk4_pkg::DATA_W - 1){kop[31]}}, kop, 1'b0};
			end
		end
		// divide by six
		if (state_q == crk4_pkg::S_FINAL_CAP) begin
			div_q <= div_load;
			rem_q <= '0;
		end else if (state_q == crk4_pkg::S_DIV) begin
			div_q <= {div_q[crk4_pkg::DIV_W-9:0], digit};
			rem_q <= drem[2:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			plant_output_q <= x_q[0];
			saturated_q    <= sat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign plant_output = plant_output_q;
	assign saturated    = saturated_q;

endmodule

`default_nettype wire

### test/crk4_plant_checker.sv
// Result checker for companion_form_rk4_plant_step: tracks register writes, predicts
// every result with its own fixed-point RK4 plant model and compares the result channel.
// Depends on crk4_pkg for widths and register indexes.

module crk4_plant_checker #(
	parameter int ORDER = 3
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [crk4_pkg::REG_IDX_W-1:0]      wr_index,
	input  wire logic [crk4_pkg::COEF_W-1:0]         wr_data,
	input  wire logic                                in_valid,
	input  wire logic                                in_stall,
	input  wire logic signed [crk4_pkg::DATA_W-1:0]  drive,
	input  wire logic                                out_valid,
	input  wire logic                                out_stall,
	input  wire logic signed [crk4_pkg::DATA_W-1:0]  plant_output,
	input  wire logic                                saturated,
	output int                                       pending,
	output int                                       mismatches,
	output int                                       results_seen,
	output int                                       clipped_seen
);

	localparam int FRAC_Q16  = 16;
	localparam int FRAC_STEP = 24;
	localparam longint FINAL_DIV = 64'sd100663296;   // 6 * 2^24

	typedef logic signed [crk4_pkg::DATA_W-1:0] q16_t;
	typedef q16_t [ORDER-1:0] q16_vec_t;
	typedef struct packed {
		q16_t y;
		logic clip;
	} plant_result_t;

	// plant registers and state as the block should hold them
	longint        coef_a [crk4_pkg::NUM_COEF];
	longint        gain_b;
	longint        step_h;
	q16_vec_t      plant_x;
	plant_result_t result_q [$];
	plant_result_t predicted;
	int            bad_count;
	int            seen_count;
	int            clip_count;

	function automatic q16_t clip_q16(input longint v, inout bit clipped);
		q16_t r;
		r = v[crk4_pkg::DATA_W-1:0];
		if (v > 64'sd2147483647) begin
			r = 32'sh7fff_ffff;
			clipped = 1'b1;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
			clipped = 1'b1;
		end
		return r;
	endfunction

	// division rounded toward minus infinity
	function automatic longint floor_div(input longint v, input longint d);
		longint q;
		q = v / d;
		if ((v % d) != 0 && v < 0)
			q = q - 1;
		return q;
	endfunction

	// companion-form derivative: shift up, last row is -sum(a*x) + b*u
	function automatic q16_vec_t slope_of(input q16_vec_t x, input longint u, inout bit clipped);
		q16_vec_t k;
		longint   acc;
		acc = gain_b * u;
		for (int i = 0; i < ORDER - 1; i++)
			k[i] = x[i+1];
		for (int i = 0; i < ORDER; i++)
			acc -= coef_a[i] * longint'(x[i]);
		k[ORDER-1] = clip_q16(acc >>> FRAC_Q16, clipped);
		return k;
	endfunction

	// x + h*k scaled down by 2^shift (2^25 gives the half step)
	function automatic q16_vec_t stage_point(input q16_vec_t x, input q16_vec_t k, input int shift,
			inout bit clipped);
		q16_vec_t p;
		for (int i = 0; i < ORDER; i++)
			p[i] = clip_q16(longint'(x[i]) + ((step_h * longint'(k[i])) >>> shift), clipped);
		return p;
	endfunction

	function automatic plant_result_t rk4_advance(input longint u);
		q16_vec_t      k1, k2, k3, k4, xs;
		longint        weighted;
		bit            clipped;
		plant_result_t r;
		clipped = 1'b0;
		k1 = slope_of(plant_x, u, clipped);
		xs = stage_point(plant_x, k1, FRAC_STEP + 1, clipped);
		k2 = slope_of(xs, u, clipped);
		xs = stage_point(plant_x, k2, FRAC_STEP + 1, clipped);
		k3 = slope_of(xs, u, clipped);
		xs = stage_point(plant_x, k3, FRAC_STEP, clipped);
		k4 = slope_of(xs, u, clipped);
		for (int i = 0; i < ORDER; i++) begin
			weighted = longint'(k1[i]) + 2 * longint'(k2[i]) + 2 * longint'(k3[i])
				+ longint'(k4[i]);
			plant_x[i] = clip_q16(longint'(plant_x[i]) + floor_div(step_h * weighted, FINAL_DIV),
				clipped);
		end
		r.y    = plant_x[0];
		r.clip = clipped;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (coef_a[j])
				coef_a[j] = 0;
			gain_b     = 0;
			step_h     = longint'(crk4_pkg::STEP_RESET);
			plant_x    = '0;
			result_q.delete();
			bad_count  = 0;
			seen_count = 0;
			clip_count = 0;
			pending      <= 0;
			mismatches   <= 0;
			results_seen <= 0;
			clipped_seen <= 0;
		end else begin
			// register writes; unknown indexes fall through
			if (wr_en) begin
				if (wr_index <= crk4_pkg::REG_COEF_4)
					coef_a[wr_index] = longint'($signed(wr_data));
				else if (wr_index == crk4_pkg::REG_GAIN)
					gain_b = longint'($signed(wr_data));
				else if (wr_index == crk4_pkg::REG_STEP)
					step_h = longint'(wr_data);
			end

			// drive transfer: advance the model
			if (in_valid && !in_stall)
				result_q.push_back(rk4_advance(longint'(drive)));

			// result transfer: compare with the oldest prediction
			if (out_valid && !out_stall) begin
				seen_count++;
				if (saturated)
					clip_count++;
				if (result_q.size() == 0) begin
					$error("result with no drive sample outstanding: plant_output %0d",
						plant_output);
					bad_count++;
				end else begin
					predicted = result_q.pop_front();
					if (plant_output !== predicted.y) begin
						$error("plant_output: expected %0d, got %0d", predicted.y, plant_output);
						bad_count++;
					end
					if (saturated !== predicted.clip) begin
						$error("saturated: expected %0d, got %0d", predicted.clip, saturated);
						bad_count++;
					end
				end
			end

			pending      <= result_q.size();
			mismatches   <= bad_count;
			results_seen <= seen_count;
			clipped_seen <= clip_count;
		end
	end

endmodule

### test/tb_companion_form_rk4_plant_step.sv
// Top-level bench for companion_form_rk4_plant_step: clock, reset, register settings,
// drive samples and result stalls; the verdict comes from crk4_plant_checker.
// Depends on crk4_pkg, the block and test/crk4_plant_checker.sv.

module tb_companion_form_rk4_plant_step;

	localparam int PLANT_ORDER   = 3;
	localparam int TOTAL_ITEMS   = 1150;
	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 60;

	// not mapped, must be ignored
	localparam logic [crk4_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [crk4_pkg::COEF_W-1:0] Q8_ONE   = 24'd65536;
	localparam logic [crk4_pkg::COEF_W-1:0] Q8_THREE = 24'd196608;
	localparam logic [crk4_pkg::COEF_W-1:0] CFG_MAX  = 24'h7f_ffff;
	localparam logic [crk4_pkg::COEF_W-1:0] CFG_MIN  = 24'h80_0000;
	localparam logic [crk4_pkg::COEF_W-1:0] CFG_ALL  = 24'hff_ffff;
	localparam logic [crk4_pkg::COEF_W-1:0] STEP_CENTI = 24'd167772; // h = 0.01
	localparam logic signed [crk4_pkg::DATA_W-1:0] DRIVE_MAX = 32'sh7fff_ffff;
	localparam logic signed [crk4_pkg::DATA_W-1:0] DRIVE_MIN = 32'sh8000_0000;

	logic                                  clk = 1'b0;
	logic                                  arst_n;
	logic                                  wr_en;
	logic [crk4_pkg::REG_IDX_W-1:0]        wr_index;
	logic [crk4_pkg::COEF_W-1:0]           wr_data;
	logic                                  in_valid;
	logic                                  in_stall;
	logic signed [crk4_pkg::DATA_W-1:0]    drive;
	logic                                  out_valid;
	logic                                  out_stall = 1'b0;
	logic signed [crk4_pkg::DATA_W-1:0]    plant_output;
	logic                                  saturated;

	int   pending;
	int   mismatches;
	int   results_seen;
	int   clipped_seen;
	int   sent = 0;
	int   settings_loaded = 1;   // reset values count as the first setting
	int   quiet_cycles = 0;
	int   stall_hold = 0;
	logic no_gaps = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	companion_form_rk4_plant_step #(.ORDER(PLANT_ORDER)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.drive        (drive),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.plant_output (plant_output),
		.saturated    (saturated)
	);

	crk4_plant_checker #(.ORDER(PLANT_ORDER)) plant_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.drive        (drive),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.plant_output (plant_output),
		.saturated    (saturated),
		.pending      (pending),
		.mismatches   (mismatches),
		.results_seen (results_seen),
		.clipped_seen (clipped_seen)
	);

	// result side: random stall bursts, none in the calm stretch
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			out_stall  <= 1'b1;
			stall_hold <= stall_hold - 1;
		end else if (!no_gaps && $urandom_range(99) < 10) begin
			out_stall  <= 1'b1;
			stall_hold <= int'($urandom_range(0, 5));
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog: cycles without any transfer or register write
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic reg_write(input logic [crk4_pkg::REG_IDX_W-1:0] idx,
			input logic [crk4_pkg::COEF_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
	endtask

	// drain the block, then write all registers (and sometimes the unmapped index)
	task automatic load_plant(input logic [crk4_pkg::COEF_W-1:0] c0, c1, c2, c3, c4, gain,
			step);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		reg_write(crk4_pkg::REG_COEF_0, c0);
		reg_write(crk4_pkg::REG_COEF_0 + 3'd1, c1);
		reg_write(crk4_pkg::REG_COEF_0 + 3'd2, c2);
		reg_write(crk4_pkg::REG_COEF_0 + 3'd3, c3);
		reg_write(crk4_pkg::REG_COEF_4, c4);
		reg_write(crk4_pkg::REG_GAIN, gain);
		if ($urandom_range(1) == 1)
			reg_write(REG_SPARE, crk4_pkg::COEF_W'($urandom));
		reg_write(crk4_pkg::REG_STEP, step);
		@(posedge clk);
		wr_en <= 1'b0;
		settings_loaded++;
	endtask

	// one drive transfer, with an optional idle gap ahead of it
	task automatic send_drive(input logic signed [crk4_pkg::DATA_W-1:0] u);
		int gap;
		gap = 0;
		if (!no_gaps && $urandom_range(99) < 30)
			gap = int'($urandom_range(1, 120));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		drive    <= u;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		no_gaps <= (sent >= 450 && sent < 650);
	endtask

	function automatic logic signed [crk4_pkg::DATA_W-1:0] random_drive();
		int pick;
		pick = $urandom_range(9);
		if (pick <= 5)
			return int'($urandom_range(0, 4194303)) - 2097152;   // within +-32.0
		else if (pick == 6)
			return $urandom;
		else if (pick == 7)
			return int'($urandom_range(0, 268435455)) - 134217728;
		else if (pick == 8) begin
			case ($urandom_range(4))
				0: return DRIVE_MAX;
				1: return DRIVE_MIN;
				2: return 1;
				3: return -1;
				default: return 0;
			endcase
		end
		return 0;
	endfunction

	// mostly damped plants with moderate steps, plus raw and extreme settings
	task automatic random_plant();
		int kind;
		logic [crk4_pkg::COEF_W-1:0] c0, c1, c2, c3, c4, gain, step;
		kind = $urandom_range(9);
		c0   = crk4_pkg::COEF_W'($urandom_range(0, 262144));
		c1   = crk4_pkg::COEF_W'($urandom_range(0, 262144));
		c2   = crk4_pkg::COEF_W'($urandom_range(0, 262144));
		c3   = crk4_pkg::COEF_W'($urandom);
		c4   = crk4_pkg::COEF_W'($urandom);
		gain = crk4_pkg::COEF_W'(int'($urandom_range(0, 524288)) - 262144);
		step = crk4_pkg::COEF_W'($urandom_range(0, 4194304));
		if (kind == 6 || kind == 7) begin
			c0   = crk4_pkg::COEF_W'($urandom);
			c1   = crk4_pkg::COEF_W'($urandom);
			c2   = crk4_pkg::COEF_W'($urandom);
			gain = crk4_pkg::COEF_W'($urandom);
			step = crk4_pkg::COEF_W'($urandom);
		end else if (kind == 8) begin
			c0   = $urandom_range(1) ? CFG_MAX : CFG_MIN;
			c1   = $urandom_range(1) ? CFG_MAX : CFG_MIN;
			c2   = $urandom_range(1) ? CFG_MAX : CFG_MIN;
			c3   = $urandom_range(1) ? CFG_MAX : CFG_MIN;
			c4   = $urandom_range(1) ? CFG_MAX : CFG_MIN;
			gain = $urandom_range(1) ? CFG_MAX : CFG_MIN;
			step = CFG_ALL;
		end else if (kind == 9) begin
			step = $urandom_range(1) ? CFG_ALL : '0;
		end
		load_plant(c0, c1, c2, c3, c4, gain, step);
	endtask

	initial begin
		int burst;
		arst_n   = 1'b0;
		wr_en    = 1'b0;
		wr_index = '0;
		wr_data  = '0;
		in_valid = 1'b0;
		drive    = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// reset settings: zero gain keeps the plant at rest
		send_drive(0);
		send_drive(DRIVE_MAX);
		send_drive(DRIVE_MIN);

		// (s+1)^3 with unit gain; unused coefficients parked at their extremes
		load_plant(Q8_ONE, Q8_THREE, Q8_THREE, CFG_MAX, CFG_MIN, Q8_ONE, STEP_CENTI);
		send_drive(32'sd65536);
		send_drive(32'sd65536);
		send_drive(1);
		send_drive(-1);
		send_drive(DRIVE_MAX);
		send_drive(DRIVE_MIN);
		send_drive(0);

		// extreme coefficients, gain and step push the plant into clipping
		load_plant(CFG_MAX, CFG_MIN, CFG_MAX, CFG_MIN, CFG_MAX, CFG_MAX, CFG_ALL);
		send_drive(DRIVE_MAX);
		send_drive(DRIVE_MIN);
		send_drive(DRIVE_MAX);
		send_drive(0);
		load_plant(CFG_MIN, CFG_MIN, CFG_MIN, CFG_MAX, CFG_MAX, CFG_MIN, CFG_ALL);
		send_drive(DRIVE_MIN);
		send_drive(DRIVE_MAX);

		// zero step: state must hold whatever the drive
		load_plant(Q8_ONE, Q8_ONE, Q8_ONE, '0, '0, CFG_MIN, '0);
		send_drive(DRIVE_MAX);
		send_drive(-12345);
		send_drive(0);

		// random settings, each followed by a burst of drive samples
		while (sent < TOTAL_ITEMS) begin
			random_plant();
			burst = $urandom_range(40, 120);
			repeat (burst) begin
				if (sent < TOTAL_ITEMS)
					send_drive(random_drive());
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d drive samples over %0d register settings", sent,
			settings_loaded);
		$display("%0d results compared, %0d of them flagged as clipped", results_seen,
			clipped_seen);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
